>>> rtl/deghost_softmax_pixel_blend_macros.svh
// Assertion macros for the deghost softmax pixel blend.
`ifndef DEGHOST_SOFTMAX_PIXEL_BLEND_MACROS_SVH
`define DEGHOST_SOFTMAX_PIXEL_BLEND_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DSPB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dspb check failed");
// next-cycle implication
`define DSPB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dspb check failed");
`else
`define DSPB_ASSERT_IMP(name, ante, cons)
`define DSPB_ASSERT_NXT(name, ante, cons)
`endif
`endif

>>> rtl/dspb_pkg.sv
// Shared types, constants and the exponential table of the pixel blend.
package dspb_pkg;

  localparam int WFB            = 16;  // weight fraction bits
  localparam int EXP_TABLE_BITS = 10;
  localparam int EXP_RANGE_LOG2 = 4;
  localparam int STEP_BITS      = EXP_TABLE_BITS - EXP_RANGE_LOG2;
  localparam int EXP_ENTRIES    = 1 << EXP_TABLE_BITS;

  localparam int              WIDTH_W     = 14;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 14'd4096;
  localparam logic [7:0]      FULL_SCALE  = 8'd255;

  typedef struct packed {
    logic [19:0] right_flow_mag;
    logic [19:0] left_flow_mag;
    logic [7:0]  right_alpha;
    logic [7:0]  right_blue;
    logic [7:0]  right_green;
    logic [7:0]  right_red;
    logic [7:0]  left_alpha;
    logic [7:0]  left_blue;
    logic [7:0]  left_green;
    logic [7:0]  left_red;
  } in_item_t;

  typedef logic [WFB:0] exp_val_t;
  typedef exp_val_t exp_tab_t [EXP_ENTRIES];

  // long division for table construction at elaboration
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    int          j;
    q = '0;
    r = '0;
    for (j = 63; j >= 0; j--) begin
      r = {r[63:0], a[j]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-i/2^STEP_BITS) in Q1.WFB, built by repeated fixed-point products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] c30;
    logic [63:0] v30;
    logic [63:0] half;
    int          n;
    int          i;
    sum  = 64'd1 << 60;
    term = 64'd1 << 60;
    for (n = 1; n <= 24; n++) begin
      if (term != 64'd0) begin
        term = udiv64(term, 64'(n) << STEP_BITS);
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    c30  = (sum + (64'd1 << 29)) >> 30;
    v30  = 64'd1 << 30;
    half = 64'd1 << (30 - WFB - 1);
    for (i = 0; i < EXP_ENTRIES; i++) begin
      tab[i] = exp_val_t'((v30 + half) >> (30 - WFB));
      v30    = (v30 * c30 + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> rtl/dspb_delay.sv
// Enabled shift line that carries a field alongside the pipeline.
module dspb_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign q = pipe_r[DEPTH-1];

endmodule

>>> rtl/dspb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dspb_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 9,
  parameter int QUO_W = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // quotient must fit QUO_W bits, so the top part of num is below den
  logic [DEN_W-1:0] rem_r [QUO_W];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rin;
    logic [DEN_W-1:0] din;
    logic [QUO_W-1:0] lin;
    logic [QUO_W-1:0] qin;
    logic [DEN_W:0]   trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign rin = DEN_W'(num >> QUO_W);
      assign din = den;
      assign lin = num[QUO_W-1:0];
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign lin = low_r[k-1];
      assign qin = quo_r[k-1];
    end

    assign trial = {rin, lin[QUO_W-1]};
    assign fit   = trial >= {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fit ? DEN_W'(trial - {1'b0, din}) : DEN_W'(trial);
        den_r[k] <= din;
        low_r[k] <= lin << 1;
        quo_r[k] <= (qin << 1) | QUO_W'(fit);
      end
    end
  end

  assign quo = quo_r[QUO_W-1];

endmodule

>>> rtl/deghost_softmax_pixel_blend.sv
// Deghosting pixel blend: per-pixel softmax-weighted mix of two views.
//
// in_*  : one item per pixel (left/right RGBA plus a flow magnitude per side).
// out_* : one blended RGBA item per input item, in order.
// cfg_* : write of image_width (14 bits, 0 acts as 1); always ready. Write it
//         only while no item is in flight.
// The datapath is a fixed pipeline of 3*WFB+30 = 78 register stages: the
// weight divider, the flow-scaled exponent dividers and the logistic divider
// each take one stage per quotient bit. One item per cycle is taken and
// delivered while the output is not stalled.
// The whole pipeline advances together: when out_tvalid is high and
// out_tready low, every stage holds and in_tready drops, so nothing is
// lost or repeated; items resume at full rate once the output is taken.
// Reset clears all valid bits (output empty) and sets image_width to 4096.
`include "deghost_softmax_pixel_blend_macros.svh"

module deghost_softmax_pixel_blend (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // left_red, left_green, left_blue, left_alpha, right_red, right_green,
  // right_blue, right_alpha (8 each), left_flow_mag, right_flow_mag (20 each)
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_red, out_green, out_blue, out_alpha (8 each)
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data
);

  localparam int W    = dspb_pkg::WFB;
  localparam int STEP = dspb_pkg::STEP_BITS;

  localparam int XQ_W = 6 + W;
  localparam int FN_W = 29 + W;
  localparam int FQ_W = 20 + W;
  localparam int Z_W  = 21 + W;

  localparam int POS_B    = W;
  localparam int POS_X    = 2;
  localparam int POS_T    = POS_X + 1;
  localparam int POS_G    = POS_T + W + 1;
  localparam int POS_F    = POS_B + 1 + FQ_W;
  localparam int POS_E    = POS_F + 3;
  localparam int POS_P    = POS_E + W + 1;
  localparam int POS_W    = POS_P + 2;
  localparam int POS_C    = POS_P + 3;
  localparam int POS_O    = POS_P + 4;
  localparam int NST      = POS_O + 1;

  localparam logic [W:0] ONE = {1'b1, {W{1'b0}}};

  logic                    en;
  logic [NST-1:0]          vld_r;
  logic [13:0]             wid_r;
  logic [13:0]             wid_eff;
  dspb_pkg::in_item_t      in_r;
  dspb_pkg::in_item_t      pix_w;
  dspb_pkg::in_item_t      pix_c_r;

  assign en         = out_tready || !vld_r[POS_O];
  assign in_tready  = en;
  assign out_tvalid = vld_r[POS_O];
  assign cfg_ready  = 1'b1;
  assign wid_eff    = (wid_r == 14'd0) ? 14'd1 : wid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      wid_r <= dspb_pkg::WIDTH_RESET;
    end else begin
      if (cfg_valid) wid_r <= cfg_data;
      if (en) vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) in_r <= dspb_pkg::in_item_t'(in_tdata);
  end

  // ---- stage 0: alpha weight divider and colour difference
  logic [7:0]      dr, dg, db;
  logic [9:0]      dsum;
  logic [13:0]     dn_r;
  logic [21:0]     dq_prod;
  logic [W-1:0]    bl;
  logic [XQ_W-1:0] xq_r;

  assign dr = (in_r.left_red > in_r.right_red) ? in_r.left_red - in_r.right_red
                                               : in_r.right_red - in_r.left_red;
  assign dg = (in_r.left_green > in_r.right_green) ?
              in_r.left_green - in_r.right_green : in_r.right_green - in_r.left_green;
  assign db = (in_r.left_blue > in_r.right_blue) ? in_r.left_blue - in_r.right_blue
                                                 : in_r.right_blue - in_r.left_blue;
  assign dsum = 10'(dr) + 10'(dg) + 10'(db);

  // x = floor(dn * 2^16 / 255) = 257*dn + floor(dn / 255), dn <= 15300 (W = 16)
  assign dq_prod = (22'(dn_r) + 22'd1) * 22'd257;

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r <= 14'(dsum) * 14'd20;
      xq_r <= XQ_W'(dn_r) * XQ_W'(257) + XQ_W'(dq_prod[21:16]);
    end
  end

  dspb_div #(.NUM_W(8 + W), .DEN_W(9), .QUO_W(W)) u_div_b (
    .clk (clk), .en (en),
    .num ({in_r.left_alpha, {W{1'b0}}}),
    .den (9'(in_r.left_alpha) + 9'(in_r.right_alpha)),
    .quo (bl)
  );

  // ---- tanh factor: g = (1 - t) / (1 + t)
  logic [W:0] t_r;
  logic [W:0] gq;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= (|xq_r[XQ_W-1:W+4]) ? '0 : dspb_pkg::EXP_TAB[xq_r[W+3:W-STEP]];
    end
  end

  dspb_div #(.NUM_W(2 * W + 1), .DEN_W(W + 2), .QUO_W(W + 1)) u_div_g (
    .clk (clk), .en (en),
    .num ({ONE - t_r, {W{1'b0}}}),
    .den ((W + 2)'(ONE) + (W + 2)'(t_r)),
    .quo (gq)
  );

  // ---- flow-scaled exponents
  logic [39:0]     flow_b;
  logic [W:0]      br_b;
  logic [W+8:0]    bl200, br200;
  logic [FN_W-1:0] pl_r, pr_r;
  logic [FQ_W-1:0] ql, qr;

  dspb_delay #(.WIDTH(40), .DEPTH(POS_B)) u_dly_flow (
    .clk (clk), .en (en), .d ({in_r.right_flow_mag, in_r.left_flow_mag}), .q (flow_b)
  );

  assign br_b  = ONE - {1'b0, bl};
  assign bl200 = (W + 9)'(bl) * (W + 9)'(200);
  assign br200 = (W + 9)'(br_b) * (W + 9)'(200);

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= FN_W'(bl200) * FN_W'(flow_b[19:0]);
      pr_r <= FN_W'(br200) * FN_W'(flow_b[39:20]);
    end
  end

  dspb_div #(.NUM_W(FN_W), .DEN_W(22), .QUO_W(FQ_W)) u_div_fl (
    .clk (clk), .en (en), .num (pl_r), .den ({wid_eff, 8'h00}), .quo (ql)
  );

  dspb_div #(.NUM_W(FN_W), .DEN_W(22), .QUO_W(FQ_W)) u_div_fr (
    .clk (clk), .en (en), .num (pr_r), .den ({wid_eff, 8'h00}), .quo (qr)
  );

  logic [W-1:0]       bl_z;
  logic [W:0]         br_z;
  logic [Z_W-1:0]     zl_r, zr_r, zdiff;
  logic               ge_r, big_r, ge_e_r;
  logic [STEP+3:0]    idx_r;
  logic [W:0]         e_r;

  dspb_delay #(.WIDTH(W), .DEPTH(POS_F - POS_B)) u_dly_bz (
    .clk (clk), .en (en), .d (bl), .q (bl_z)
  );

  assign br_z  = ONE - {1'b0, bl_z};
  assign zdiff = (zl_r >= zr_r) ? zl_r - zr_r : zr_r - zl_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zl_r   <= Z_W'((W + 4)'(bl_z) * (W + 4)'(10)) + Z_W'(ql);
      zr_r   <= Z_W'((W + 4)'(br_z) * (W + 4)'(10)) + Z_W'(qr);
      ge_r   <= zl_r >= zr_r;
      big_r  <= |zdiff[Z_W-1:W+4];
      idx_r  <= zdiff[W+3:W-STEP];
      e_r    <= big_r ? '0 : dspb_pkg::EXP_TAB[idx_r];
      ge_e_r <= ge_r;
    end
  end

  // ---- logistic: p = 1 / (1 + e)
  logic [W:0] pq;
  logic       ge_p;
  logic [W-1:0] bl_m;
  logic [W:0] g_m, br_m, omg, sl, sr;

  dspb_div #(.NUM_W(2 * W + 1), .DEN_W(W + 2), .QUO_W(W + 1)) u_div_p (
    .clk (clk), .en (en),
    .num ({1'b1, {(2 * W){1'b0}}}),
    .den ((W + 2)'(ONE) + (W + 2)'(e_r)),
    .quo (pq)
  );

  dspb_delay #(.WIDTH(1), .DEPTH(POS_P - POS_E)) u_dly_ge (
    .clk (clk), .en (en), .d (ge_e_r), .q (ge_p)
  );
  dspb_delay #(.WIDTH(W), .DEPTH(POS_P - POS_B)) u_dly_bm (
    .clk (clk), .en (en), .d (bl), .q (bl_m)
  );
  dspb_delay #(.WIDTH(W + 1), .DEPTH(POS_P - POS_G)) u_dly_g (
    .clk (clk), .en (en), .d (gq), .q (g_m)
  );

  assign br_m = ONE - {1'b0, bl_m};
  assign omg  = ONE - g_m;
  assign sl   = ge_p ? pq : ONE - pq;
  assign sr   = ONE - sl;

  // ---- final weights
  logic [2*W+1:0] m1_r, m2_r, m3_r, m4_r;
  logic [2*W+2:0] wsum_l, wsum_r;
  logic [W:0]     wl_r, wr_r;

  assign wsum_l = (2 * W + 3)'(m1_r) + (2 * W + 3)'(m2_r);
  assign wsum_r = (2 * W + 3)'(m3_r) + (2 * W + 3)'(m4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= (2 * W + 2)'(bl_m) * (2 * W + 2)'(omg);
      m2_r <= (2 * W + 2)'(sl) * (2 * W + 2)'(g_m);
      m3_r <= (2 * W + 2)'(br_m) * (2 * W + 2)'(omg);
      m4_r <= (2 * W + 2)'(sr) * (2 * W + 2)'(g_m);
      wl_r <= wsum_l[2*W:W];
      wr_r <= wsum_r[2*W:W];
    end
  end

  // ---- colour mix
  logic [7:0]   cl [3];
  logic [7:0]   cr [3];
  logic [W+8:0] prl_r [3];
  logic [W+8:0] prr_r [3];

  dspb_delay #(.WIDTH($bits(dspb_pkg::in_item_t)), .DEPTH(POS_W)) u_dly_pix (
    .clk (clk), .en (en), .d (in_r), .q (pix_w)
  );

  assign cl[0] = pix_w.left_red;
  assign cl[1] = pix_w.left_green;
  assign cl[2] = pix_w.left_blue;
  assign cr[0] = pix_w.right_red;
  assign cr[1] = pix_w.right_green;
  assign cr[2] = pix_w.right_blue;

  always_ff @(posedge clk) begin
    if (en) begin
      pix_c_r <= pix_w;
      for (int k = 0; k < 3; k++) begin
        prl_r[k] <= (W + 9)'(cl[k]) * (W + 9)'(wl_r);
        prr_r[k] <= (W + 9)'(cr[k]) * (W + 9)'(wr_r);
      end
    end
  end

  // ---- output stage
  logic [W+9:0] vsum [3];
  logic [7:0]   mix  [3];
  logic [7:0]   amax;
  logic         blend;
  logic         alpha_hi;
  logic [31:0]  out_nxt;
  logic [31:0]  out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsum[k] = (W + 10)'(prl_r[k]) + (W + 10)'(prr_r[k]);
      mix[k]  = (vsum[k][W+9:W] > 10'd255) ? 8'hFF : vsum[k][W+7:W];
    end
  end

  assign amax = (pix_c_r.left_alpha > pix_c_r.right_alpha) ? pix_c_r.left_alpha
                                                           : pix_c_r.right_alpha;
  assign alpha_hi = (12'(amax) * 12'd10) > 12'd255;
  assign blend    = (pix_c_r.left_alpha != 8'd0) && (pix_c_r.right_alpha != 8'd0);

  always_comb begin
    if (blend) begin
      out_nxt = {8'hFF, mix[2], mix[1], mix[0]};
    end else if (pix_c_r.left_alpha != 8'd0) begin
      out_nxt = {alpha_hi ? 8'hFF : 8'h00, pix_c_r.left_blue, pix_c_r.left_green,
                 pix_c_r.left_red};
    end else if (pix_c_r.right_alpha != 8'd0) begin
      out_nxt = {alpha_hi ? 8'hFF : 8'h00, pix_c_r.right_blue, pix_c_r.right_green,
                 pix_c_r.right_red};
    end else begin
      out_nxt = {8'h00, 24'h000000};
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_tdata = out_r;

  // bl+br and sl+sr are both one, so the floored weights sum to one or one less
  `DSPB_ASSERT_IMP(a_weight_sum, vld_r[POS_W],
    ((W + 2)'(wl_r) + (W + 2)'(wr_r) == (W + 2)'(ONE)) ||
    ((W + 2)'(wl_r) + (W + 2)'(wr_r) == (W + 2)'(ONE) - (W + 2)'(1)))
  `DSPB_ASSERT_NXT(a_blend_alpha, vld_r[POS_C] && en && blend, out_tdata[31:24] == 8'hFF)
  `DSPB_ASSERT_NXT(a_stall_hold, !en, $stable(vld_r))

endmodule
